/* rtl/svcp_pkg.sv */
// Shared types, constants and a helper function for the SQL value compare predicate unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none
package svcp_pkg;

   localparam int unsigned MAX_VALUE_BYTES = 4096;
   localparam int unsigned LANES           = 8;

   localparam int unsigned LEN_W      = 13;
   localparam int unsigned BEAT_W     = 10;
   localparam int unsigned POS_W      = 14;
   localparam int unsigned BYTES_W    = 64;
   localparam int unsigned OP_W       = 3;

   localparam logic [BEAT_W-1:0] BEAT_CAP = 10'd1023;
   localparam logic [7:0]        BLANK    = 8'h20;

   typedef enum logic [1:0] {
      SIGN_EQ = 2'd0,
      SIGN_GT = 2'd1,
      SIGN_LT = 2'd2
   } sign_type;

   typedef enum logic [OP_W-1:0] {
      OP_EQ = 3'd0,
      OP_NE = 3'd1,
      OP_GT = 3'd2,
      OP_LT = 3'd3,
      OP_GE = 3'd4,
      OP_LE = 3'd5
   } op_type;

   typedef struct packed {
      logic               first_beat;
      logic               last_beat;
      logic [LEN_W-1:0]   left_len;
      logic [LEN_W-1:0]   right_len;
      logic [OP_W-1:0]    op;
      logic               char_mode;
      logic [BYTES_W-1:0] left_bytes;
      logic [BYTES_W-1:0] right_bytes;
   } req_data_type;

   typedef struct packed {
      logic matches_res;
      logic null_operand;
   } rsp_data_type;

   // Per-beat control shared by all lanes.
   typedef struct packed {
      logic [LEN_W-1:0] min_len;
      logic [LEN_W-1:0] max_len;
      logic             left_longer;
      logic             char_mode;
   } lane_ctrl_type;

   // What one lane found: hit means this byte pair fixes the order.
   typedef struct packed {
      logic hit;
      logic left_greater;
   } lane_result_type;

   typedef struct packed {
      logic     decided;
      sign_type sign;
   } verdict_type;

   // Applies the comparison operator to the final ordering.
   function automatic logic eval_op(input logic [OP_W-1:0] op, input sign_type sign);
      logic res;
      res = 1'b0;
      unique case (op)
         OP_EQ:   res = (sign == SIGN_EQ);
         OP_NE:   res = (sign != SIGN_EQ);
         OP_GT:   res = (sign == SIGN_GT);
         OP_LT:   res = (sign == SIGN_LT);
         OP_GE:   res = (sign != SIGN_LT);
         OP_LE:   res = (sign != SIGN_GT);
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

/* rtl/svcp_lane.sv */
// One byte-pair compare lane of the SQL value compare predicate unit.
// Depends on svcp_pkg for the lane control and result structs.
`default_nettype none
module svcp_lane #(
   parameter int unsigned LaneIdx = 0
) (
   input  wire logic [svcp_pkg::POS_W-1:0] base_pos,
   input  wire logic [7:0]                 left_byte,
   input  wire logic [7:0]                 right_byte,
   input  wire svcp_pkg::lane_ctrl_type    ctrl,
   output svcp_pkg::lane_result_type       result
);

   logic [svcp_pkg::POS_W-1:0] pos;
   logic [svcp_pkg::POS_W-1:0] min_ext;
   logic [svcp_pkg::POS_W-1:0] max_ext;
   logic [7:0]                 tail_byte;
   logic                       in_common;
   logic                       in_tail;

   always_comb begin
      pos       = base_pos + svcp_pkg::POS_W'(LaneIdx);
      min_ext   = svcp_pkg::POS_W'(ctrl.min_len);
      max_ext   = svcp_pkg::POS_W'(ctrl.max_len);
      in_common = (pos < min_ext);
      in_tail   = !in_common && (pos < max_ext);
      tail_byte = ctrl.left_longer ? left_byte : right_byte;

      result.hit = (in_common && (left_byte != right_byte)) ||
                   (in_tail && ctrl.char_mode && (tail_byte != svcp_pkg::BLANK));
      // Inside the common part the bytes decide; in the tail the longer side wins.
      result.left_greater = in_common ? (left_byte > right_byte) : ctrl.left_longer;
   end

endmodule
`default_nettype wire

/* rtl/svcp_merge.sv */
// Merge stage: folds the lane findings of one beat into the running verdict.
// Depends on svcp_pkg for the lane result and verdict structs.
`default_nettype none
module svcp_merge #(
   parameter int unsigned Lanes = svcp_pkg::LANES
) (
   input  wire svcp_pkg::lane_result_type lane_res [Lanes],
   input  wire logic                      active,
   input  wire svcp_pkg::verdict_type     verdict_cur,
   output svcp_pkg::verdict_type          verdict_nxt
);

   logic any_hit;
   logic first_gt;

   // The lowest lane that hits is the first differing byte.
   always_comb begin
      any_hit  = 1'b0;
      first_gt = 1'b0;
      for (int i = Lanes - 1; i >= 0; i--) begin
         if (lane_res[i].hit) begin
            any_hit  = 1'b1;
            first_gt = lane_res[i].left_greater;
         end
      end

      verdict_nxt = verdict_cur;
      if (active && !verdict_cur.decided && any_hit) begin
         verdict_nxt.decided = 1'b1;
         verdict_nxt.sign    = first_gt ? svcp_pkg::SIGN_GT : svcp_pkg::SIGN_LT;
      end
   end

endmodule
`default_nettype wire

/* rtl/sql_value_compare_predicate_unit.sv */
// The result of a transaction carrying last_beat is registered and is on rsp_* in the cycle after it is taken.
// Throughput: one beat per cycle while req_ready is high; all lanes of a beat are compared in the cycle it is taken.
// The running verdict is updated in that same cycle, so beat n+1 may follow beat n directly.
// A new beat is held off only while an unaccepted result sits in the output register.
// Reset (synchronous, active high) clears the beat index, the verdict and the output valid.
// Depends on svcp_pkg, svcp_lane and svcp_merge.
`default_nettype none
module sql_value_compare_predicate_unit #(
   parameter int unsigned MaxValueBytes = svcp_pkg::MAX_VALUE_BYTES,
   parameter int unsigned Lanes         = svcp_pkg::LANES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire svcp_pkg::req_data_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output svcp_pkg::rsp_data_type      rsp_data
);

   localparam int unsigned LW = svcp_pkg::LEN_W;
   localparam int unsigned BW = svcp_pkg::BEAT_W;
   localparam int unsigned PW = svcp_pkg::POS_W;

   // Running state of the comparison in progress.
   logic [BW-1:0]          beat_index_ff, beat_index_in;
   svcp_pkg::verdict_type  verdict_ff, verdict_in;

   // Output register; it parts the request side from the response side.
   logic                   rsp_valid_ff, rsp_valid_in;
   svcp_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic [LW-1:0]          left_len_c;
   logic [LW-1:0]          right_len_c;
   logic [BW-1:0]          beat_index_eff;
   svcp_pkg::verdict_type  verdict_eff;
   svcp_pkg::verdict_type  verdict_merged;
   logic                   active;
   logic [PW-1:0]          base_pos;
   svcp_pkg::lane_ctrl_type  lane_ctrl;
   svcp_pkg::lane_result_type lane_res [Lanes];
   svcp_pkg::sign_type     final_sign;
   logic                   null_seen;

   // A new transaction is taken whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lengths above the configured maximum count as the maximum.
   always_comb begin
      left_len_c  = (32'(req_data.left_len) > 32'(MaxValueBytes)) ?
                    LW'(MaxValueBytes) : req_data.left_len;
      right_len_c = (32'(req_data.right_len) > 32'(MaxValueBytes)) ?
                    LW'(MaxValueBytes) : req_data.right_len;

      lane_ctrl.min_len     = (left_len_c <= right_len_c) ? left_len_c : right_len_c;
      lane_ctrl.max_len     = (left_len_c <= right_len_c) ? right_len_c : left_len_c;
      lane_ctrl.left_longer = (left_len_c > right_len_c);
      lane_ctrl.char_mode   = req_data.char_mode;
   end

   // A first beat starts from a clean verdict; otherwise the running one continues.
   always_comb begin
      if (req_data.first_beat) begin
         beat_index_eff      = '0;
         verdict_eff.decided = 1'b0;
         verdict_eff.sign    = svcp_pkg::SIGN_EQ;
      end else begin
         beat_index_eff = beat_index_ff;
         verdict_eff    = verdict_ff;
      end
      // The beat index saturates; a beat at the cap compares nothing.
      active   = (beat_index_eff < svcp_pkg::BEAT_CAP);
      base_pos = PW'(beat_index_eff) * PW'(Lanes);
   end

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      svcp_lane #(
         .LaneIdx (g)
      ) u_lane (
         .base_pos   (base_pos),
         .left_byte  (req_data.left_bytes[8*g +: 8]),
         .right_byte (req_data.right_bytes[8*g +: 8]),
         .ctrl       (lane_ctrl),
         .result     (lane_res[g])
      );
   end

   svcp_merge #(
      .Lanes (Lanes)
   ) u_merge (
      .lane_res    (lane_res),
      .active      (active),
      .verdict_cur (verdict_eff),
      .verdict_nxt (verdict_merged)
   );

   // Final ordering: a differing byte wins; otherwise binary mode orders by length.
   always_comb begin
      if (verdict_merged.decided) begin
         final_sign = verdict_merged.sign;
      end else if (!req_data.char_mode && (left_len_c != right_len_c)) begin
         final_sign = (left_len_c > right_len_c) ? svcp_pkg::SIGN_GT : svcp_pkg::SIGN_LT;
      end else begin
         final_sign = svcp_pkg::SIGN_EQ;
      end
      null_seen = (left_len_c == '0) || (right_len_c == '0);
      rsp_data_in.null_operand = null_seen;
      rsp_data_in.matches_res  = !null_seen && svcp_pkg::eval_op(req_data.op, final_sign);
   end

   // Next-state logic for the verdict and the output register.
   always_comb begin
      beat_index_in = beat_index_ff;
      verdict_in    = verdict_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (req_take) begin
         if (req_data.last_beat) begin
            // The comparison ends here; the state goes back to its reset values.
            beat_index_in      = '0;
            verdict_in.decided = 1'b0;
            verdict_in.sign    = svcp_pkg::SIGN_EQ;
            rsp_valid_in       = 1'b1;
         end else begin
            beat_index_in = active ? (beat_index_eff + BW'(1)) : beat_index_eff;
            verdict_in    = verdict_merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_index_ff      <= '0;
         verdict_ff.decided <= 1'b0;
         verdict_ff.sign    <= svcp_pkg::SIGN_EQ;
         rsp_valid_ff       <= 1'b0;
      end else begin
         beat_index_ff <= beat_index_in;
         verdict_ff    <= verdict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is loaded only with a last beat.
   always_ff @(posedge clock) begin
      if (req_take && req_data.last_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/svcp_checker.sv */
// Port-level checker for sql_value_compare_predicate_unit, attached by a bind below.
// Depends on svcp_pkg for the request and response payload types.
`default_nettype none
module svcp_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire svcp_pkg::req_data_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire svcp_pkg::rsp_data_type rsp_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A NULL operand never yields a true predicate.
   a_null_false: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.null_operand |-> !rsp_data.matches_res)
      else $error("predicate true with a NULL operand");

   // A last beat with a zero length produces a NULL result in the next cycle.
   a_null_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_beat &&
      (req_data.left_len == '0 || req_data.right_len == '0)
      |=> rsp_valid && rsp_data.null_operand)
      else $error("NULL operand not reported");

   // A beat that is not last produces no result when the output is free.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.last_beat && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("result without a last beat");

   // Input is held off only while a result waits.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind sql_value_compare_predicate_unit svcp_checker u_svcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
